[src/tekd_pkg.sv]
`default_nettype none

package tekd_pkg;

  // longest escape sequence that is buffered
  localparam int SEQ_DEPTH = 20;
  localparam int SEQ_CNT_W = $clog2(SEQ_DEPTH + 1);
  // sequence characters after ESC that are compared at fixed places
  localparam int SEQ_HEAD  = 4;

  localparam int KIND_W = 6;
  localparam int CP_W   = 21;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_Z     = 8'h5A;

  localparam logic [KIND_W-1:0] K_CHAR        = 6'd0;
  localparam logic [KIND_W-1:0] K_ENTER       = 6'd1;
  localparam logic [KIND_W-1:0] K_BACKSPACE   = 6'd2;
  localparam logic [KIND_W-1:0] K_ESCAPE      = 6'd3;
  localparam logic [KIND_W-1:0] K_TIMEOUT     = 6'd4;
  localparam logic [KIND_W-1:0] K_MOUSE       = 6'd5;
  localparam logic [KIND_W-1:0] K_MOUSE_SGR   = 6'd6;
  localparam logic [KIND_W-1:0] K_F1          = 6'd7;
  localparam logic [KIND_W-1:0] K_F5          = 6'd11;
  localparam logic [KIND_W-1:0] K_F6          = 6'd12;
  localparam logic [KIND_W-1:0] K_F7          = 6'd13;
  localparam logic [KIND_W-1:0] K_F8          = 6'd14;
  localparam logic [KIND_W-1:0] K_F9          = 6'd15;
  localparam logic [KIND_W-1:0] K_F10         = 6'd16;
  localparam logic [KIND_W-1:0] K_F11         = 6'd17;
  localparam logic [KIND_W-1:0] K_F12         = 6'd18;
  localparam logic [KIND_W-1:0] K_HOME        = 6'd19;
  localparam logic [KIND_W-1:0] K_END         = 6'd20;
  localparam logic [KIND_W-1:0] K_PGUP        = 6'd21;
  localparam logic [KIND_W-1:0] K_PGDN        = 6'd22;
  localparam logic [KIND_W-1:0] K_DELETE      = 6'd23;
  localparam logic [KIND_W-1:0] K_SHIFT_TAB   = 6'd24;
  localparam logic [KIND_W-1:0] K_PASTE_BEGIN = 6'd25;
  localparam logic [KIND_W-1:0] K_PASTE_END   = 6'd26;
  localparam logic [KIND_W-1:0] K_UP          = 6'd27;
  localparam logic [KIND_W-1:0] K_DOWN        = 6'd28;
  localparam logic [KIND_W-1:0] K_RIGHT       = 6'd29;
  localparam logic [KIND_W-1:0] K_LEFT        = 6'd30;
  localparam logic [KIND_W-1:0] K_NONE        = 6'h3F;

  // modifier offsets applied to the plain arrow codes
  localparam logic [KIND_W-1:0] MOD_SHIFT     = 6'd4;
  localparam logic [KIND_W-1:0] MOD_CTRL      = 6'd8;
  localparam logic [KIND_W-1:0] MOD_ALT       = 6'd12;
  localparam logic [KIND_W-1:0] MOD_ALT_SHIFT = 6'd16;

  typedef enum logic [3:0] {
    U8_ACCEPT = 4'd0,
    U8_TAIL1  = 4'd1,
    U8_TAIL2  = 4'd2,
    U8_TAIL3  = 4'd3,
    U8_E0     = 4'd4,
    U8_ED     = 4'd5,
    U8_F0     = 4'd6,
    U8_F4     = 4'd7
  } utf8_state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CP_W-1:0]   cp;
  } key_result_t;

  typedef struct packed {
    logic        last;
    key_result_t res;
  } out_word_t;

  function automatic key_result_t plain_result(input logic [CP_W-1:0] c);
    key_result_t r;
    r.kind = K_CHAR;
    r.cp   = c;
    if (c == CP_W'(CH_LF)) begin
      r.kind = K_ENTER;
      r.cp   = '0;
    end else if (c == CP_W'(CH_DEL)) begin
      r.kind = K_BACKSPACE;
      r.cp   = '0;
    end
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] modified_arrow(input logic [KIND_W-1:0] base,
                                                      input logic [7:0] last);
    logic [KIND_W-1:0] k;
    case (last)
      CH_2:    k = base + MOD_SHIFT;
      CH_5:    k = base + MOD_CTRL;
      CH_3:    k = base + MOD_ALT;
      CH_4:    k = base + MOD_ALT_SHIFT;
      default: k = base;
    endcase
    return k;
  endfunction

  // ESC [ params ~ ; c2..c4 are the characters after ESC [
  function automatic logic [KIND_W-1:0] tilde_key(input logic [SEQ_CNT_W-1:0] cnt,
                                                 input logic [7:0] c2,
                                                 input logic [7:0] c3,
                                                 input logic [7:0] c4);
    logic [KIND_W-1:0] k;
    k = K_NONE;
    if (cnt == SEQ_CNT_W'(3)) begin
      case (c2)
        CH_1:    k = K_HOME;
        CH_3:    k = K_DELETE;
        CH_4:    k = K_END;
        CH_5:    k = K_PGUP;
        CH_6:    k = K_PGDN;
        default: k = K_NONE;
      endcase
    end else if (cnt == SEQ_CNT_W'(5)) begin
      if (c2 == CH_2 && c3 == CH_0 && c4 == CH_0) begin
        k = K_PASTE_BEGIN;
      end else if (c2 == CH_2 && c3 == CH_0 && c4 == CH_1) begin
        k = K_PASTE_END;
      end
    end else if (cnt >= SEQ_CNT_W'(4)) begin
      if (c2 == CH_1) begin
        case (c3)
          CH_5:    k = K_F5;
          CH_7:    k = K_F6;
          CH_8:    k = K_F7;
          CH_9:    k = K_F8;
          default: k = K_NONE;
        endcase
      end else if (c2 == CH_2) begin
        case (c3)
          CH_0:    k = K_F9;
          CH_1:    k = K_F10;
          CH_3:    k = K_F11;
          CH_4:    k = K_F12;
          default: k = K_NONE;
        endcase
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[src/terminal_escape_key_decoder_unit.sv]
// Path: a word accepted on s_* passes the input register, then is decoded
//   into the result queue that drives m_*.
// Throughput: one input word per cycle while the result queue has room for two
//   keys; a word that yields two keys is absorbed by the four-entry result queue.
// Reset (rst, synchronous): empties the input register and the queue, clears the
//   escape buffer count and returns the UTF-8 decoder to its accept state.
`default_nettype none

module terminal_escape_key_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tuser,   // [0] action (1 = read window expired)
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [20:0] codepoint, [23:21] zero
  output logic [5:0]       m_tuser,   // [5:0] key_kind
  output logic             m_tlast    // last_of_run
);

  localparam int KW = tekd_pkg::KIND_W;
  localparam int CW = tekd_pkg::CP_W;
  localparam int NW = tekd_pkg::SEQ_CNT_W;
  localparam int PW = tekd_pkg::FIFO_PTR_W;
  localparam int FW = tekd_pkg::FIFO_CNT_W;

  // input register
  logic       in_valid;
  logic       in_action;
  logic [7:0] in_byte;

  // decoder state
  logic [NW-1:0]         seq_count;
  logic [7:0]            seq_last;
  logic [7:0]            seq_head [tekd_pkg::SEQ_HEAD];
  tekd_pkg::utf8_state_t u8_state;
  logic [CW-1:0]         u8_part;

  // result queue
  tekd_pkg::out_word_t fifo [tekd_pkg::FIFO_DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [FW-1:0]       fcount;

  logic proc;
  logic pop;
  logic ev_timeout;

  assign proc       = in_valid && (fcount <= FW'(tekd_pkg::FIFO_DEPTH - 2));
  assign s_tready   = !in_valid || proc;
  assign ev_timeout = in_action || (in_byte == tekd_pkg::CH_NUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_byte   <= s_tdata;
    end
  end

  // ---------------- UTF-8 decode ----------------
  logic [7:0]            u8_lo;
  logic [7:0]            u8_hi;
  tekd_pkg::utf8_state_t u8_after;
  logic                  u8_lead;
  logic [CW-1:0]         u8_shift;
  tekd_pkg::utf8_state_t u8_state_next;
  logic [CW-1:0]         u8_part_next;
  logic                  cp_ok;
  logic [CW-1:0]         cp_val;

  assign u8_lead  = (u8_state == tekd_pkg::U8_ACCEPT);
  assign u8_shift = {u8_part[CW-7:0], in_byte[5:0]};

  // continuation byte window and the state that follows it
  always_comb begin
    u8_lo    = 8'h80;
    u8_hi    = 8'hBF;
    u8_after = tekd_pkg::U8_ACCEPT;
    case (u8_state)
      tekd_pkg::U8_TAIL1: u8_after = tekd_pkg::U8_ACCEPT;
      tekd_pkg::U8_TAIL2: u8_after = tekd_pkg::U8_TAIL1;
      tekd_pkg::U8_TAIL3: u8_after = tekd_pkg::U8_TAIL2;
      tekd_pkg::U8_E0: begin
        u8_lo    = 8'hA0;
        u8_after = tekd_pkg::U8_TAIL1;
      end
      tekd_pkg::U8_ED: begin
        u8_hi    = 8'h9F;
        u8_after = tekd_pkg::U8_TAIL1;
      end
      tekd_pkg::U8_F0: begin
        u8_lo    = 8'h90;
        u8_after = tekd_pkg::U8_TAIL2;
      end
      tekd_pkg::U8_F4: begin
        u8_hi    = 8'h8F;
        u8_after = tekd_pkg::U8_TAIL2;
      end
      default: u8_after = tekd_pkg::U8_ACCEPT;
    endcase
  end

  // next state
  always_comb begin
    u8_state_next = tekd_pkg::U8_ACCEPT;
    u8_part_next  = '0;
    if (u8_lead) begin
      if (in_byte inside {[8'hC2:8'hDF]}) begin
        u8_state_next = tekd_pkg::U8_TAIL1;
        u8_part_next  = CW'(in_byte[4:0]);
      end else if (in_byte inside {[8'hE0:8'hEF]}) begin
        u8_state_next = (in_byte == 8'hE0) ? tekd_pkg::U8_E0 :
                        (in_byte == 8'hED) ? tekd_pkg::U8_ED : tekd_pkg::U8_TAIL2;
        u8_part_next  = CW'(in_byte[3:0]);
      end else if (in_byte inside {[8'hF0:8'hF4]}) begin
        u8_state_next = (in_byte == 8'hF0) ? tekd_pkg::U8_F0 :
                        (in_byte == 8'hF4) ? tekd_pkg::U8_F4 : tekd_pkg::U8_TAIL3;
        u8_part_next  = CW'(in_byte[2:0]);
      end
    end else if (in_byte >= u8_lo && in_byte <= u8_hi) begin
      u8_state_next = u8_after;
      u8_part_next  = (u8_after == tekd_pkg::U8_ACCEPT) ? '0 : u8_shift;
    end
  end

  // decoded character
  always_comb begin
    cp_ok  = 1'b0;
    cp_val = CW'(in_byte);
    if (u8_lead) begin
      cp_ok = !in_byte[7];
    end else if (in_byte >= u8_lo && in_byte <= u8_hi &&
                 u8_after == tekd_pkg::U8_ACCEPT) begin
      cp_ok  = 1'b1;
      cp_val = u8_shift;
    end
  end

  // ---------------- escape sequence parser ----------------
  logic       c_ascii;
  logic [7:0] c8;
  logic       c_esc;
  logic [NW-1:0] cnt_m1;

  assign c8      = cp_val[7:0];
  assign c_ascii = (cp_val[CW-1:8] == '0);
  assign c_esc   = c_ascii && (c8 == tekd_pkg::CH_ESC);
  assign cnt_m1  = seq_count - NW'(1);

  logic [1:0]            hc_n;
  tekd_pkg::key_result_t hc_r0;
  tekd_pkg::key_result_t hc_r1;
  logic [NW-1:0]         cnt_next;
  logic [7:0]            last_next;
  logic                  hw_en;
  logic [1:0]            hw_idx;
  logic [7:0]            hw_dat;
  logic                  do_app;
  logic [KW-1:0]         fin_kind;

  // final character of ESC [
  always_comb begin
    fin_kind = tekd_pkg::K_NONE;
    if (c_ascii) begin
      case (c8)
        tekd_pkg::CH_M:     fin_kind = tekd_pkg::K_MOUSE;
        tekd_pkg::CH_LT:    fin_kind = tekd_pkg::K_MOUSE_SGR;
        tekd_pkg::CH_A:     fin_kind = tekd_pkg::modified_arrow(tekd_pkg::K_UP, seq_last);
        tekd_pkg::CH_B:     fin_kind = tekd_pkg::modified_arrow(tekd_pkg::K_DOWN, seq_last);
        tekd_pkg::CH_C:     fin_kind = tekd_pkg::modified_arrow(tekd_pkg::K_RIGHT, seq_last);
        tekd_pkg::CH_D:     fin_kind = tekd_pkg::modified_arrow(tekd_pkg::K_LEFT, seq_last);
        tekd_pkg::CH_H:     fin_kind = tekd_pkg::K_HOME;
        tekd_pkg::CH_F:     fin_kind = tekd_pkg::K_END;
        tekd_pkg::CH_I:     fin_kind = tekd_pkg::K_PGUP;
        tekd_pkg::CH_G:     fin_kind = tekd_pkg::K_PGDN;
        tekd_pkg::CH_Z:     fin_kind = tekd_pkg::K_SHIFT_TAB;
        tekd_pkg::CH_TILDE: fin_kind = tekd_pkg::tilde_key(seq_count, seq_head[1],
                                                           seq_head[2], seq_head[3]);
        default:            fin_kind = tekd_pkg::K_NONE;
      endcase
    end
  end

  always_comb begin
    hc_n      = 2'd0;
    hc_r0     = '0;
    hc_r1     = '0;
    cnt_next  = seq_count;
    last_next = seq_last;
    hw_en     = 1'b0;
    hw_idx    = 2'd0;
    hw_dat    = c8;
    do_app    = 1'b0;
    if (seq_count == '0) begin
      if (c_esc) begin
        cnt_next  = NW'(1);
        last_next = tekd_pkg::CH_ESC;
      end else begin
        hc_n  = 2'd1;
        hc_r0 = tekd_pkg::plain_result(cp_val);
      end
    end else if (seq_last == tekd_pkg::CH_ESC && c_esc) begin
      // second ESC reports the first and opens a new sequence
      cnt_next   = NW'(1);
      last_next  = tekd_pkg::CH_ESC;
      hc_n       = 2'd1;
      hc_r0.kind = tekd_pkg::K_ESCAPE;
    end else if (c_ascii && c8 == tekd_pkg::CH_O) begin
      do_app = 1'b1;
    end else if (seq_count >= NW'(2) && seq_head[0] == tekd_pkg::CH_O) begin
      cnt_next = '0;
      if (c_ascii && c8 >= tekd_pkg::CH_P && c8 <= tekd_pkg::CH_S) begin
        hc_n       = 2'd1;
        hc_r0.kind = tekd_pkg::K_F1 + KW'(c8 - tekd_pkg::CH_P);
      end
    end else if (seq_last == tekd_pkg::CH_ESC) begin
      if (!(c_ascii && c8 == tekd_pkg::CH_LBRK)) begin
        // ESC then an ordinary char: escape, then the char itself
        cnt_next   = '0;
        hc_n       = 2'd2;
        hc_r0.kind = tekd_pkg::K_ESCAPE;
        hc_r1      = tekd_pkg::plain_result(cp_val);
      end else begin
        cnt_next  = NW'(2);
        last_next = tekd_pkg::CH_LBRK;
        hw_en     = 1'b1;
        hw_idx    = 2'd0;
        hw_dat    = tekd_pkg::CH_LBRK;
      end
    end else if (seq_count >= NW'(2) && seq_head[0] == tekd_pkg::CH_LBRK) begin
      if (c_ascii && ((c8 >= tekd_pkg::CH_0 && c8 <= tekd_pkg::CH_9) ||
                      c8 == tekd_pkg::CH_SEMI)) begin
        do_app = 1'b1;
      end else begin
        cnt_next = '0;
        if (fin_kind != tekd_pkg::K_NONE) begin
          hc_n       = 2'd1;
          hc_r0.kind = fin_kind;
        end
      end
    end else begin
      cnt_next = '0;
    end

    if (do_app) begin
      if (seq_count < NW'(tekd_pkg::SEQ_DEPTH)) begin
        cnt_next  = seq_count + NW'(1);
        last_next = c8;
        if (seq_count <= NW'(tekd_pkg::SEQ_HEAD)) begin
          hw_en  = 1'b1;
          hw_idx = cnt_m1[1:0];
        end
      end else begin
        cnt_next = '0;  // overflow drops the sequence
      end
    end
  end

  // ---------------- results of this word ----------------
  logic [1:0]          res_n;
  tekd_pkg::out_word_t res0;
  tekd_pkg::out_word_t res1;

  always_comb begin
    res_n = 2'd0;
    res0  = '0;
    res1  = '0;
    if (ev_timeout) begin
      res_n         = 2'd1;
      res0.res.kind = (in_action && seq_count != '0 && seq_last == tekd_pkg::CH_ESC) ?
                      tekd_pkg::K_ESCAPE : tekd_pkg::K_TIMEOUT;
    end else if (cp_ok) begin
      res_n    = hc_n;
      res0.res = hc_r0;
      res1.res = hc_r1;
    end
    res0.last = (res_n == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_count <= '0;
      u8_state  <= tekd_pkg::U8_ACCEPT;
      u8_part   <= '0;
    end else if (proc) begin
      if (ev_timeout) begin
        seq_count <= '0;
        u8_state  <= tekd_pkg::U8_ACCEPT;
        u8_part   <= '0;
      end else begin
        u8_state <= u8_state_next;
        u8_part  <= u8_part_next;
        if (cp_ok) begin
          seq_count <= cnt_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && !ev_timeout && cp_ok) begin
      seq_last <= last_next;
      if (hw_en) begin
        seq_head[hw_idx] <= hw_dat;
      end
    end
  end

  // ---------------- result queue ----------------
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (fcount != '0);
  assign m_tdata  = {3'b0, fifo[rd_ptr].res.cp};
  assign m_tuser  = fifo[rd_ptr].res.kind;
  assign m_tlast  = fifo[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (proc && res_n != 2'd0) begin
      fifo[wr_ptr] <= res0;
    end
    if (proc && res_n == 2'd2) begin
      fifo[wr_ptr + PW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fcount <= '0;
    end else begin
      if (proc) begin
        wr_ptr <= wr_ptr + PW'(res_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      fcount <= fcount + (proc ? FW'(res_n) : FW'(0)) - (pop ? FW'(1) : FW'(0));
    end
  end

  // ---------------- checks ----------------
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fcount <= FW'(tekd_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_seq_bound: assert property (@(posedge clk) disable iff (rst)
    seq_count <= NW'(tekd_pkg::SEQ_DEPTH))
    else $error("escape buffer count beyond depth");

  a_pair_escape: assert property (@(posedge clk) disable iff (rst)
    proc && res_n == 2'd2 |-> res0.res.kind == tekd_pkg::K_ESCAPE && !res0.last)
    else $error("two-key word must start with a non-final escape");

  a_timeout_clear: assert property (@(posedge clk) disable iff (rst)
    proc && ev_timeout |=> seq_count == '0 && u8_state == tekd_pkg::U8_ACCEPT)
    else $error("timeout did not clear decoder state");

endmodule

`default_nettype wire

[sim/terminal_escape_key_decoder_unit_tb.sv]
`default_nettype none

module terminal_escape_key_decoder_unit_tb;

  localparam int KIND_W    = tekd_pkg::KIND_W;
  localparam int CP_W      = tekd_pkg::CP_W;
  localparam int SEQ_DEPTH = tekd_pkg::SEQ_DEPTH;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;

  localparam int SINK_ALWAYS   = 0;
  localparam int SINK_RANDOM   = 1;
  localparam int SINK_PERIODIC = 2;

  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CP_W-1:0]   cp;
    logic              last;
  } key_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [5:0]  m_tuser;
  logic        m_tlast;

  terminal_escape_key_decoder_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // decoder shadow state
  logic [7:0]            esc_buf [SEQ_DEPTH];
  int unsigned           esc_len = 0;
  tekd_pkg::utf8_state_t u8_st = tekd_pkg::U8_ACCEPT;
  logic [CP_W-1:0]       u8_acc = '0;

  key_word_t expected_keys[$];
  key_word_t step_keys[$];

  int  items_sent = 0;
  int  keys_checked = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  kinds_seen [0:63];

  int  burst_left = 0;
  bit  src_idle_on = 1'b1;
  int  sink_mode = SINK_ALWAYS;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  sink_tick = 0;

  key_word_t want_word;

  function automatic void add_key(input logic [KIND_W-1:0] kind,
                                  input logic [CP_W-1:0] cp);
    key_word_t w;
    w.kind = kind;
    w.cp   = cp;
    w.last = 1'b0;
    step_keys.push_back(w);
  endfunction

  function automatic void add_plain(input logic [CP_W-1:0] c);
    if (c == CP_W'(tekd_pkg::CH_LF)) add_key(tekd_pkg::K_ENTER, '0);
    else if (c == CP_W'(tekd_pkg::CH_DEL)) add_key(tekd_pkg::K_BACKSPACE, '0);
    else add_key(tekd_pkg::K_CHAR, c);
  endfunction

  function automatic void esc_push(input logic [7:0] c);
    if (esc_len < SEQ_DEPTH) begin
      esc_buf[esc_len] = c;
      esc_len++;
    end else begin
      esc_len = 0;
    end
  endfunction

  function automatic logic [KIND_W-1:0] arrow_kind(input logic [KIND_W-1:0] base);
    logic [KIND_W-1:0] k;
    case (esc_buf[esc_len - 1])
      tekd_pkg::CH_2: k = base + tekd_pkg::MOD_SHIFT;
      tekd_pkg::CH_5: k = base + tekd_pkg::MOD_CTRL;
      tekd_pkg::CH_3: k = base + tekd_pkg::MOD_ALT;
      tekd_pkg::CH_4: k = base + tekd_pkg::MOD_ALT_SHIFT;
      default:        k = base;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] tilde_kind();
    logic [KIND_W-1:0] k;
    k = tekd_pkg::K_NONE;
    if (esc_len == 3) begin
      case (esc_buf[2])
        tekd_pkg::CH_1: k = tekd_pkg::K_HOME;
        tekd_pkg::CH_3: k = tekd_pkg::K_DELETE;
        tekd_pkg::CH_4: k = tekd_pkg::K_END;
        tekd_pkg::CH_5: k = tekd_pkg::K_PGUP;
        tekd_pkg::CH_6: k = tekd_pkg::K_PGDN;
        default: k = tekd_pkg::K_NONE;
      endcase
    end else if (esc_len == 5) begin
      if (esc_buf[2] == tekd_pkg::CH_2 && esc_buf[3] == tekd_pkg::CH_0) begin
        if (esc_buf[4] == tekd_pkg::CH_0) k = tekd_pkg::K_PASTE_BEGIN;
        else if (esc_buf[4] == tekd_pkg::CH_1) k = tekd_pkg::K_PASTE_END;
      end
    end else if (esc_len >= 4) begin
      if (esc_buf[2] == tekd_pkg::CH_1) begin
        case (esc_buf[3])
          tekd_pkg::CH_5: k = tekd_pkg::K_F5;
          tekd_pkg::CH_7: k = tekd_pkg::K_F6;
          tekd_pkg::CH_8: k = tekd_pkg::K_F7;
          tekd_pkg::CH_9: k = tekd_pkg::K_F8;
          default: k = tekd_pkg::K_NONE;
        endcase
      end else if (esc_buf[2] == tekd_pkg::CH_2) begin
        case (esc_buf[3])
          tekd_pkg::CH_0: k = tekd_pkg::K_F9;
          tekd_pkg::CH_1: k = tekd_pkg::K_F10;
          tekd_pkg::CH_3: k = tekd_pkg::K_F11;
          tekd_pkg::CH_4: k = tekd_pkg::K_F12;
          default: k = tekd_pkg::K_NONE;
        endcase
      end
    end
    return k;
  endfunction

  function automatic void parse_char(input logic [CP_W-1:0] c);
    logic [7:0]        tail;
    logic [KIND_W-1:0] kind;
    if (esc_len == 0) begin
      if (c == CP_W'(tekd_pkg::CH_ESC)) begin
        esc_buf[0] = tekd_pkg::CH_ESC;
        esc_len = 1;
      end else begin
        add_plain(c);
      end
      return;
    end
    tail = esc_buf[esc_len - 1];
    if (tail == tekd_pkg::CH_ESC && c == CP_W'(tekd_pkg::CH_ESC)) begin
      esc_buf[0] = tekd_pkg::CH_ESC;
      esc_len = 1;
      add_key(tekd_pkg::K_ESCAPE, '0);
      return;
    end
    // 'O' is buffered inside any open sequence, not only right after ESC
    if (esc_buf[0] == tekd_pkg::CH_ESC && c == CP_W'(tekd_pkg::CH_O)) begin
      esc_push(tekd_pkg::CH_O);
      return;
    end
    if (esc_len >= 2 && esc_buf[1] == tekd_pkg::CH_O) begin
      esc_len = 0;
      if (c >= CP_W'(tekd_pkg::CH_P) && c <= CP_W'(tekd_pkg::CH_S))
        add_key(tekd_pkg::K_F1 + KIND_W'(c - CP_W'(tekd_pkg::CH_P)), '0);
      return;
    end
    if (tail == tekd_pkg::CH_ESC) begin
      if (c != CP_W'(tekd_pkg::CH_LBRK)) begin
        esc_len = 0;
        add_key(tekd_pkg::K_ESCAPE, '0);
        add_plain(c);
      end else begin
        esc_buf[1] = tekd_pkg::CH_LBRK;
        esc_len = 2;
      end
      return;
    end
    if (esc_len >= 2 && esc_buf[1] == tekd_pkg::CH_LBRK) begin
      if ((c >= CP_W'(tekd_pkg::CH_0) && c <= CP_W'(tekd_pkg::CH_9)) ||
          c == CP_W'(tekd_pkg::CH_SEMI)) begin
        esc_push(c[7:0]);
        return;
      end
      case (c)
        CP_W'(tekd_pkg::CH_M):     kind = tekd_pkg::K_MOUSE;
        CP_W'(tekd_pkg::CH_LT):    kind = tekd_pkg::K_MOUSE_SGR;
        CP_W'(tekd_pkg::CH_A):     kind = arrow_kind(tekd_pkg::K_UP);
        CP_W'(tekd_pkg::CH_B):     kind = arrow_kind(tekd_pkg::K_DOWN);
        CP_W'(tekd_pkg::CH_C):     kind = arrow_kind(tekd_pkg::K_RIGHT);
        CP_W'(tekd_pkg::CH_D):     kind = arrow_kind(tekd_pkg::K_LEFT);
        CP_W'(tekd_pkg::CH_H):     kind = tekd_pkg::K_HOME;
        CP_W'(tekd_pkg::CH_F):     kind = tekd_pkg::K_END;
        CP_W'(tekd_pkg::CH_I):     kind = tekd_pkg::K_PGUP;
        CP_W'(tekd_pkg::CH_G):     kind = tekd_pkg::K_PGDN;
        CP_W'(tekd_pkg::CH_Z):     kind = tekd_pkg::K_SHIFT_TAB;
        CP_W'(tekd_pkg::CH_TILDE): kind = tilde_kind();
        default:                   kind = tekd_pkg::K_NONE;
      endcase
      esc_len = 0;
      if (kind != tekd_pkg::K_NONE) add_key(kind, '0);
      return;
    end
    esc_len = 0;
  endfunction

  function automatic void utf8_reset();
    u8_st  = tekd_pkg::U8_ACCEPT;
    u8_acc = '0;
  endfunction

  // returns 1 with the codepoint once a full character is assembled
  function automatic bit utf8_take(input logic [7:0] b, output logic [CP_W-1:0] cp);
    logic [7:0]            lo, hi;
    tekd_pkg::utf8_state_t nxt;
    lo = 8'h80;
    hi = 8'hBF;
    cp = '0;
    if (u8_st == tekd_pkg::U8_ACCEPT) begin
      if (b < 8'h80) begin
        cp = CP_W'(b);
        return 1'b1;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        u8_st  = tekd_pkg::U8_TAIL1;
        u8_acc = CP_W'(b[4:0]);
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        u8_st  = (b == 8'hE0) ? tekd_pkg::U8_E0 :
                 (b == 8'hED) ? tekd_pkg::U8_ED : tekd_pkg::U8_TAIL2;
        u8_acc = CP_W'(b[3:0]);
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        u8_st  = (b == 8'hF0) ? tekd_pkg::U8_F0 :
                 (b == 8'hF4) ? tekd_pkg::U8_F4 : tekd_pkg::U8_TAIL3;
        u8_acc = CP_W'(b[2:0]);
      end else begin
        utf8_reset();
      end
      return 1'b0;
    end
    case (u8_st)
      tekd_pkg::U8_TAIL1: nxt = tekd_pkg::U8_ACCEPT;
      tekd_pkg::U8_TAIL2: nxt = tekd_pkg::U8_TAIL1;
      tekd_pkg::U8_TAIL3: nxt = tekd_pkg::U8_TAIL2;
      tekd_pkg::U8_E0: begin
        lo  = 8'hA0;
        nxt = tekd_pkg::U8_TAIL1;
      end
      tekd_pkg::U8_ED: begin
        hi  = 8'h9F;
        nxt = tekd_pkg::U8_TAIL1;
      end
      tekd_pkg::U8_F0: begin
        lo  = 8'h90;
        nxt = tekd_pkg::U8_TAIL2;
      end
      default: begin
        hi  = 8'h8F;
        nxt = tekd_pkg::U8_TAIL2;
      end
    endcase
    if (b < lo || b > hi) begin
      utf8_reset();
      return 1'b0;
    end
    u8_acc = {u8_acc[CP_W-7:0], b[5:0]};
    u8_st  = nxt;
    if (nxt == tekd_pkg::U8_ACCEPT) begin
      cp     = u8_acc;
      u8_acc = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_keys(input logic act, input logic [7:0] b);
    logic [KIND_W-1:0] kind;
    logic [CP_W-1:0]   cp;
    key_word_t         w;
    step_keys.delete();
    if (act == ACT_TIMEOUT || b == tekd_pkg::CH_NUL) begin
      kind = tekd_pkg::K_TIMEOUT;
      if (act == ACT_TIMEOUT && esc_len > 0 && esc_buf[esc_len - 1] == tekd_pkg::CH_ESC)
        kind = tekd_pkg::K_ESCAPE;
      esc_len = 0;
      utf8_reset();
      add_key(kind, '0);
    end else if (utf8_take(b, cp)) begin
      parse_char(cp);
    end
    if (step_keys.size() > 0) begin
      w = step_keys.pop_back();
      w.last = 1'b1;
      step_keys.push_back(w);
    end
    while (step_keys.size() > 0) expected_keys.push_back(step_keys.pop_front());
  endfunction

  // one word on the input side; bursts with random gaps between them
  task automatic send_word(input logic act, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = src_idle_on ? $urandom_range(0, 5) : 0;
      if (src_idle_on && $urandom_range(0, 9) == 0) gap = $urandom_range(10, 25);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predict_keys(act, b);
  endtask

  task automatic send_text(input string txt);
    int i;
    for (i = 0; i < txt.len(); i++) send_word(ACT_BYTE, txt[i]);
  endtask

  task automatic send_codepoint(input logic [CP_W-1:0] cp);
    if (cp < 'h80) begin
      send_word(ACT_BYTE, cp[7:0]);
    end else if (cp < 'h800) begin
      send_word(ACT_BYTE, {3'b110, cp[10:6]});
      send_word(ACT_BYTE, {2'b10, cp[5:0]});
    end else if (cp < 'h10000) begin
      send_word(ACT_BYTE, {4'b1110, cp[15:12]});
      send_word(ACT_BYTE, {2'b10, cp[11:6]});
      send_word(ACT_BYTE, {2'b10, cp[5:0]});
    end else begin
      send_word(ACT_BYTE, {5'b11110, cp[20:18]});
      send_word(ACT_BYTE, {2'b10, cp[17:12]});
      send_word(ACT_BYTE, {2'b10, cp[11:6]});
      send_word(ACT_BYTE, {2'b10, cp[5:0]});
    end
  endtask

  task automatic wait_all_keys();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_keys.size() != 0);
  endtask

  function automatic string tilde_params(input int sel);
    case (sel)
      0: return "1";    1: return "3";    2: return "4";    3: return "5";
      4: return "6";    5: return "2";    6: return "15";   7: return "17";
      8: return "18";   9: return "19";   10: return "20";  11: return "21";
      12: return "23";  13: return "24";  14: return "200"; 15: return "201";
      16: return "16";  17: return "";    18: return "99";  19: return "1;5";
      20: return "202"; default: return "2001";
    endcase
  endfunction

  // one well-formed or deliberately broken input phrase
  task automatic send_random_phrase();
    int          pick, n, i;
    logic [CP_W-1:0] cp;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      case ($urandom_range(0, 3))
        0: send_word(ACT_BYTE, tekd_pkg::CH_LF);
        1: send_word(ACT_BYTE, tekd_pkg::CH_DEL);
        2: send_word(ACT_BYTE, 8'($urandom_range(1, 8'h1A)));
        default: send_word(ACT_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
      endcase
    end else if (pick < 25) begin
      case ($urandom_range(0, 2))
        0: cp = CP_W'($urandom_range('h80, 'h7FF));
        1: begin
          cp = CP_W'($urandom_range('h800, 'hFFFF));
          if (cp[15:11] == 5'b11011) cp = cp ^ CP_W'('h1000);
        end
        default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
      endcase
      send_codepoint(cp);
    end else if (pick < 30) begin
      // broken UTF-8: stray continuation, bad second byte, NUL inside a character
      send_word(ACT_BYTE, 8'($urandom_range(8'hC0, 8'hFF)));
      case ($urandom_range(0, 2))
        0: send_word(ACT_BYTE, 8'($urandom_range(8'h80, 8'hFF)));
        1: send_word(ACT_BYTE, tekd_pkg::CH_NUL);
        default: send_word(ACT_BYTE, 8'($urandom_range(1, 8'h7F)));
      endcase
    end else if (pick < 40) begin
      send_word(ACT_BYTE, tekd_pkg::CH_ESC);
      send_word(ACT_BYTE, tekd_pkg::CH_O);
      if ($urandom_range(0, 3) != 0)
        send_word(ACT_BYTE, 8'($urandom_range(tekd_pkg::CH_P, tekd_pkg::CH_S)));
      else send_word(ACT_BYTE, 8'($urandom_range(1, 8'h7F)));
    end else if (pick < 55) begin
      send_word(ACT_BYTE, tekd_pkg::CH_ESC);
      send_word(ACT_BYTE, tekd_pkg::CH_LBRK);
      if ($urandom_range(0, 5) != 0) begin
        send_word(ACT_BYTE, tekd_pkg::CH_1);
        send_word(ACT_BYTE, tekd_pkg::CH_SEMI);
        case ($urandom_range(0, 4))
          0: send_word(ACT_BYTE, tekd_pkg::CH_2);
          1: send_word(ACT_BYTE, tekd_pkg::CH_3);
          2: send_word(ACT_BYTE, tekd_pkg::CH_4);
          3: send_word(ACT_BYTE, tekd_pkg::CH_5);
          default: send_word(ACT_BYTE, tekd_pkg::CH_7);
        endcase
      end
      send_word(ACT_BYTE, 8'($urandom_range(tekd_pkg::CH_A, tekd_pkg::CH_D)));
    end else if (pick < 67) begin
      send_word(ACT_BYTE, tekd_pkg::CH_ESC);
      send_word(ACT_BYTE, tekd_pkg::CH_LBRK);
      send_text(tilde_params($urandom_range(0, 21)));
      send_word(ACT_BYTE, tekd_pkg::CH_TILDE);
    end else if (pick < 73) begin
      send_word(ACT_BYTE, tekd_pkg::CH_ESC);
      send_word(ACT_BYTE, tekd_pkg::CH_LBRK);
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++)
        send_word(ACT_BYTE, 8'($urandom_range(tekd_pkg::CH_0, tekd_pkg::CH_SEMI)));
      case ($urandom_range(0, 8))
        0: c = tekd_pkg::CH_M;
        1: c = tekd_pkg::CH_LT;
        2: c = tekd_pkg::CH_H;
        3: c = tekd_pkg::CH_F;
        4: c = tekd_pkg::CH_I;
        5: c = tekd_pkg::CH_G;
        6: c = tekd_pkg::CH_Z;
        default: c = 8'($urandom_range(1, 8'h7F));
      endcase
      send_word(ACT_BYTE, c);
    end else if (pick < 78) begin
      send_word(ACT_BYTE, tekd_pkg::CH_ESC);
      case ($urandom_range(0, 3))
        0: send_word(ACT_TIMEOUT, 8'($urandom));
        1: send_word(ACT_BYTE, tekd_pkg::CH_ESC);
        2: send_word(ACT_BYTE, tekd_pkg::CH_LF);
        default: send_word(ACT_BYTE, 8'($urandom_range(1, 8'h7F)));
      endcase
    end else if (pick < 82) begin
      // long sequences, some of which run past the buffer
      send_word(ACT_BYTE, tekd_pkg::CH_ESC);
      if ($urandom_range(0, 1) == 0) begin
        send_word(ACT_BYTE, tekd_pkg::CH_LBRK);
        n = $urandom_range(16, 20);
        for (i = 0; i < n; i++)
          send_word(ACT_BYTE, 8'($urandom_range(tekd_pkg::CH_0, tekd_pkg::CH_SEMI)));
        send_word(ACT_BYTE, tekd_pkg::CH_A);
      end else begin
        n = $urandom_range(17, 21);
        for (i = 0; i < n; i++) send_word(ACT_BYTE, tekd_pkg::CH_O);
        send_word(ACT_BYTE, tekd_pkg::CH_P);
      end
    end else if (pick < 88) begin
      if ($urandom_range(0, 1) == 0) send_word(ACT_TIMEOUT, 8'($urandom));
      else send_word(ACT_BYTE, tekd_pkg::CH_NUL);
    end else begin
      send_word(($urandom_range(0, 9) == 0) ? ACT_TIMEOUT : ACT_BYTE, 8'($urandom));
    end
  endtask

  task automatic test_directed_keys();
    sink_mode = SINK_ALWAYS;
    src_idle_on = 1'b0;
    send_word(ACT_BYTE, 8'h01);
    send_word(ACT_BYTE, tekd_pkg::CH_DEL);
    send_word(ACT_BYTE, tekd_pkg::CH_LF);
    send_word(ACT_BYTE, tekd_pkg::CH_NUL);
    send_word(ACT_BYTE, 8'hFF);
    send_codepoint(CP_W'('h10FFFF));
    // surrogate lead followed by an out-of-range continuation
    send_word(ACT_BYTE, 8'hED);
    send_word(ACT_BYTE, 8'hA0);
    send_word(ACT_TIMEOUT, 8'hFF);
    send_word(ACT_BYTE, tekd_pkg::CH_ESC);
    send_word(ACT_TIMEOUT, 8'h00);
    send_word(ACT_BYTE, tekd_pkg::CH_ESC);
    send_word(ACT_BYTE, tekd_pkg::CH_ESC);
    send_word(ACT_TIMEOUT, 8'h5A);
    send_word(ACT_BYTE, tekd_pkg::CH_ESC);
    send_word(ACT_BYTE, 8'h78);
    send_text("\033[5~");
    send_text("\033[1;5A");
    wait_all_keys();
  endtask

  task automatic test_random_mix();
    int phase, target;
    for (phase = 0; phase < 6; phase++) begin
      sink_mode   = phase % 3;
      src_idle_on = (phase % 4) != 1;
      target = items_sent + 28;
      while (items_sent < target) send_random_phrase();
    end
  endtask

  // receiver holds off while words keep coming, so the input must stall
  task automatic test_output_backpressure();
    int i;
    sink_mode   = SINK_ALWAYS;
    src_idle_on = 1'b0;
    hold_req    = 1'b1;
    for (i = 0; i < 40; i++) send_word(ACT_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
    send_text("\033x\033x\033\033");
    hold_req = 1'b0;
    wait_all_keys();
  endtask

  task automatic test_pause_resume();
    int i;
    sink_mode   = SINK_RANDOM;
    src_idle_on = 1'b1;
    for (i = 0; i < 4; i++) begin
      repeat (8) send_random_phrase();
      wait_all_keys();
    end
  endtask

  task automatic finish_run();
    int i, kinds;
    sink_mode = SINK_ALWAYS;
    wait_all_keys();
    repeat (DRAIN_CYCLES) @(posedge clk);
    kinds = 0;
    for (i = 0; i <= 46; i++) if (kinds_seen[i]) kinds++;
    $display("Decoder run: %0d input words, %0d keys compared, %0d of 47 key kinds seen",
             items_sent, keys_checked, kinds);
    $display("Included UTF-8 edges, escape and CSI forms, buffer overflow and output stalls");
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_keys();
    test_random_mix();
    test_output_backpressure();
    test_pause_resume();
    test_random_mix();
    finish_run();
  end

  // receiver: own stall pattern plus one long hold-off on request
  always @(posedge clk) begin
    sink_tick <= sink_tick + 1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_ALWAYS: m_tready <= 1'b1;
        SINK_RANDOM: m_tready <= ($urandom_range(0, 99) < 55);
        default:     m_tready <= (sink_tick % 7) >= 3;
      endcase
    end
    if (!hold_req) hold_done <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_keys.size() == 0) begin
        $display("%0t: unexpected key word, expected none, got kind=%0d cp=%h last=%b",
                 $time, m_tuser, m_tdata[20:0], m_tlast);
        mismatch_count++;
      end else begin
        want_word = expected_keys.pop_front();
        keys_checked++;
        if (m_tuser != want_word.kind || m_tdata[20:0] != want_word.cp ||
            m_tlast != want_word.last || m_tdata[23:21] != 3'd0) begin
          $display("%0t: key mismatch, expected kind=%0d cp=%h last=%b pad=0,",
                   $time, want_word.kind, want_word.cp, want_word.last);
          $display("%0t:   got kind=%0d cp=%h last=%b pad=%h",
                   $time, m_tuser, m_tdata[20:0], m_tlast, m_tdata[23:21]);
          mismatch_count++;
        end else begin
          kinds_seen[want_word.kind] = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run stopped at cycle limit, %0d keys still expected",
               $time, expected_keys.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

`default_nettype wire
